@@ hw/rtl/wpcp_pkg.sv @@
// Shared types and constants for the wireless pen charge policy block.
`timescale 1ns / 1ps
`default_nettype none

package wpcp_pkg;

	localparam int unsigned TIME_W = 48;
	localparam int unsigned IVL_W  = 32;
	localparam int unsigned REV_W  = 8;
	localparam int unsigned PCT_W  = 7;
	localparam int unsigned FAIL_W = 8;
	localparam int unsigned BATT_W = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned IN_DATA_W = 64;
	localparam int unsigned OUT_DATA_W = 8;

	localparam logic [REV_W-1:0]   MIN_REVISION = 8'd2;
	localparam logic signed [BATT_W-1:0] PCT_MAX = 8'sd100;
	localparam logic signed [BATT_W-1:0] PCT_MIN = 8'sd0;
	localparam logic [FAIL_W-1:0]  FAIL_SAT = 8'hFF;

	localparam logic [REV_W-1:0]  RST_BOARD_REV  = 8'd2;
	localparam logic [IVL_W-1:0]  RST_CHECK_IVL  = 32'd1200000000;
	localparam logic [PCT_W-1:0]  RST_LOW_PCT    = 7'd75;
	localparam logic [FAIL_W-1:0] RST_FAIL_LIMIT = 8'd20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOARD_REV  = 2'd0,
		REG_CHECK_IVL  = 2'd1,
		REG_LOW_PCT    = 2'd2,
		REG_FAIL_LIMIT = 2'd3
	} reg_idx_t;

	typedef enum logic {
		CMD_POLL = 1'b0,
		CMD_END  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		POLL_NONE   = 2'd0,
		POLL_CANCEL = 2'd1,
		POLL_AGAIN  = 2'd2
	} poll_action_t;

	typedef struct packed {
		logic [REV_W-1:0]  board_revision;
		logic [IVL_W-1:0]  check_interval;
		logic [PCT_W-1:0]  low_percent;
		logic [FAIL_W-1:0] fail_limit;
	} cfg_t;

	typedef struct packed {
		cmd_t                      cmd;
		logic [TIME_W-1:0]         now_time;
		logic                      pen_removed;
		logic                      host_off;
		logic                      ext_power;
		logic signed [BATT_W-1:0]  battery_percent;
	} item_t;

	typedef struct packed {
		poll_action_t poll_action;
		logic         read_failed;
		logic         recharge_active;
		logic         stop_charger;
		logic         start_charger;
	} result_t;

endpackage

`default_nettype wire

@@ hw/rtl/wpcp_regs.sv @@
// Configuration register file of the charge policy block.
`timescale 1ns / 1ps
`default_nettype none

module wpcp_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               wr_en,
	input  wire logic [wpcp_pkg::CFG_IDX_W-1:0]     wr_index,
	input  wire logic [wpcp_pkg::CFG_DATA_W-1:0]    wr_data,
	output wpcp_pkg::cfg_t                          cfg
);
	import wpcp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.board_revision <= RST_BOARD_REV;
			cfg_q.check_interval <= RST_CHECK_IVL;
			cfg_q.low_percent    <= RST_LOW_PCT;
			cfg_q.fail_limit     <= RST_FAIL_LIMIT;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_BOARD_REV:  cfg_q.board_revision <= wr_data[REV_W-1:0];
				REG_CHECK_IVL:  cfg_q.check_interval <= wr_data[IVL_W-1:0];
				REG_LOW_PCT:    cfg_q.low_percent    <= wr_data[PCT_W-1:0];
				REG_FAIL_LIMIT: cfg_q.fail_limit     <= wr_data[FAIL_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/wpcp_step.sv @@
// Policy state and the single-pass decision logic for one word.
`timescale 1ns / 1ps
`default_nettype none

module wpcp_step (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wpcp_pkg::cfg_t  cfg,
	input  wpcp_pkg::item_t item,
	input  wire logic     advance,
	output wpcp_pkg::result_t res
);
	import wpcp_pkg::*;

	logic              charger_on_q;
	logic              latch_q;
	logic [FAIL_W-1:0] fail_cnt_q;
	logic [TIME_W-1:0] next_check_q;

	logic              charger_on_d;
	logic              latch_d;
	logic [FAIL_W-1:0] fail_cnt_d;
	logic [TIME_W-1:0] next_check_d;

	logic [TIME_W:0]   sum;
	logic [TIME_W-1:0] deadline;
	logic              pct_bad;
	logic              pct_low;
	logic [FAIL_W-1:0] fail_inc;
	logic              fail_hit;
	logic              latch_new;

	always_comb begin
		sum      = {1'b0, item.now_time} + {{(TIME_W + 1 - IVL_W){1'b0}}, cfg.check_interval};
		deadline = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
		pct_bad  = (item.battery_percent <= PCT_MIN) || (item.battery_percent > PCT_MAX);
		pct_low  = item.battery_percent[PCT_W-1:0] < cfg.low_percent;
		fail_inc = (fail_cnt_q != FAIL_SAT) ? fail_cnt_q + 8'd1 : fail_cnt_q;
		fail_hit = fail_inc >= cfg.fail_limit;
		latch_new = latch_q | pct_low;
	end

	always_comb begin
		charger_on_d = charger_on_q;
		latch_d      = latch_q;
		fail_cnt_d   = fail_cnt_q;
		next_check_d = next_check_q;
		res.start_charger = 1'b0;
		res.stop_charger  = 1'b0;
		res.read_failed   = 1'b0;
		res.poll_action   = POLL_NONE;

		priority if (item.cmd == CMD_END) begin
			next_check_d = deadline;
			res.stop_charger = 1'b1;
			charger_on_d = 1'b0;
			latch_d      = 1'b0;
			res.poll_action = POLL_AGAIN;
		end else if (cfg.board_revision < MIN_REVISION) begin
			// old board: poll ignored
		end else if (item.pen_removed || (item.host_off && !item.ext_power)) begin
			res.stop_charger = 1'b1;
			charger_on_d = 1'b0;
			latch_d      = 1'b0;
			next_check_d = '0;
			res.poll_action = POLL_CANCEL;
		end else if (item.now_time < next_check_q) begin
			res.poll_action = POLL_AGAIN;
		end else begin
			res.poll_action   = POLL_AGAIN;
			res.start_charger = !charger_on_q;
			charger_on_d      = 1'b1;
			if (pct_bad) begin
				res.read_failed = 1'b1;
				if (fail_hit) begin
					res.stop_charger = 1'b1;
					charger_on_d = 1'b0;
					fail_cnt_d   = '0;
				end else begin
					fail_cnt_d = fail_inc;
				end
			end else begin
				fail_cnt_d = '0;
				latch_d    = latch_new;
				if (!latch_new) begin
					res.stop_charger = 1'b1;
					charger_on_d = 1'b0;
				end
				next_check_d = deadline;
			end
		end
		res.recharge_active = latch_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charger_on_q <= 1'b0;
			latch_q      <= 1'b0;
			fail_cnt_q   <= '0;
			next_check_q <= '0;
		end else if (advance) begin
			charger_on_q <= charger_on_d;
			latch_q      <= latch_d;
			fail_cnt_q   <= fail_cnt_d;
			next_check_q <= next_check_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/wireless_pen_charge_policy.sv @@
// Top level of the wireless pen charge policy block.
`timescale 1ns / 1ps
`default_nettype none

// One input word gives one result word. A word is taken into an input
// register, decided by the combinational policy logic and written into
// the result register, so a result is valid once that register holds it;
// a new word is accepted every cycle while the result side keeps up.
// The input and result registers are the only buffers: with the output
// stalled the block holds one word in each register and then drops s_axis_tready.
// Configuration writes are always ready and take effect the next cycle.
module wireless_pen_charge_policy (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output      logic                               s_axis_tready,
	// [47:0] now_time, [48] pen_removed, [49] host_off, [50] ext_power,
	// [58:51] battery_percent, [63:59] zero
	input  wire logic [wpcp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// [0] cmd
	input  wire logic                               s_axis_tuser,
	output      logic                               m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// [0] start_charger, [1] stop_charger, [2] recharge_active,
	// [3] read_failed, [5:4] poll_action, [7:6] zero
	output      logic [wpcp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input  wire logic                               cfg_valid,
	output      logic                               cfg_ready,
	input  wire logic [wpcp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [wpcp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import wpcp_pkg::*;

	cfg_t    cfg;
	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    out_free;
	logic    advance;

	assign cfg_ready = 1'b1;

	wpcp_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	always_comb begin
		item_in.cmd             = cmd_t'(s_axis_tuser);
		item_in.now_time        = s_axis_tdata[TIME_W-1:0];
		item_in.pen_removed     = s_axis_tdata[TIME_W];
		item_in.host_off        = s_axis_tdata[TIME_W+1];
		item_in.ext_power       = s_axis_tdata[TIME_W+2];
		item_in.battery_percent = s_axis_tdata[TIME_W+3 +: BATT_W];
	end

	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (out_free)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			item_s1 <= item_in;
		if (advance)
			res_q <= res;
	end

	wpcp_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item    (item_s1),
		.advance (advance),
		.res     (res)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, res_q};

endmodule

`default_nettype wire

@@ hw/rtl/wpcp_check.sv @@
// Port-level checks for the charge policy block and their bind.
`timescale 1ns / 1ps
`default_nettype none

module wpcp_check (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [wpcp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import wpcp_pkg::*;

	result_t r;
	assign r = result_t'(m_axis_tdata[$bits(result_t)-1:0]);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	a_fail_again: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && r.read_failed |-> r.poll_action == POLL_AGAIN)
		else $error("read failure without reschedule");

	a_cancel: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && r.poll_action == POLL_CANCEL
		|-> r.stop_charger && !r.start_charger && !r.recharge_active)
		else $error("cancel without clean shutdown");

	a_start_again: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && r.start_charger |-> r.poll_action == POLL_AGAIN)
		else $error("start issued outside a battery check");

endmodule

bind wireless_pen_charge_policy wpcp_check u_check (.*);

`default_nettype wire

@@ bench/wireless_pen_charge_policy_tb.sv @@
// Self-checking testbench for the wireless pen charge policy block.
`timescale 1ns / 1ps

module wireless_pen_charge_policy_tb;
	import wpcp_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int LIMIT_CYCLES = 500000;
	localparam int PHASES       = 10;
	localparam int PHASE_WORDS  = 93;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	class charge_policy_sb;
		logic [REV_W-1:0]  rev;
		logic [IVL_W-1:0]  ivl;
		logic [PCT_W-1:0]  low_pct;
		logic [FAIL_W-1:0] limit;
		logic              chg_on;
		logic              latch;
		logic [FAIL_W-1:0] fails;
		logic [TIME_W-1:0] next_due;
		result_t           due_q[$];
		int                errors;

		function new();
			rev      = RST_BOARD_REV;
			ivl      = RST_CHECK_IVL;
			low_pct  = RST_LOW_PCT;
			limit    = RST_FAIL_LIMIT;
			chg_on   = 1'b0;
			latch    = 1'b0;
			fails    = '0;
			next_due = '0;
			errors   = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				REG_BOARD_REV:  rev = v[REV_W-1:0];
				REG_CHECK_IVL:  ivl = v[IVL_W-1:0];
				REG_LOW_PCT:    low_pct = v[PCT_W-1:0];
				REG_FAIL_LIMIT: limit = v[FAIL_W-1:0];
				default: ;
			endcase
		endfunction

		// next check time, clamped at the top of the time range
		function logic [TIME_W-1:0] due_after(logic [TIME_W-1:0] now);
			logic [TIME_W:0] sum;
			sum = {1'b0, now} + {{(TIME_W + 1 - IVL_W){1'b0}}, ivl};
			return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
		endfunction

		function void note_word(item_t w);
			result_t r;
			int pct;
			r = '0;
			r.poll_action = POLL_NONE;
			pct = $signed(w.battery_percent);
			if (w.cmd == CMD_END) begin
				next_due = due_after(w.now_time);
				r.stop_charger = 1'b1;
				chg_on = 1'b0;
				latch = 1'b0;
				r.poll_action = POLL_AGAIN;
			end else if (rev < MIN_REVISION) begin
				// old board: poll has no effect
			end else if (w.pen_removed || (w.host_off && !w.ext_power)) begin
				r.stop_charger = 1'b1;
				chg_on = 1'b0;
				latch = 1'b0;
				next_due = '0;
				r.poll_action = POLL_CANCEL;
			end else if (w.now_time < next_due) begin
				r.poll_action = POLL_AGAIN;
			end else begin
				r.poll_action = POLL_AGAIN;
				if (!chg_on) begin
					r.start_charger = 1'b1;
					chg_on = 1'b1;
				end
				if (pct <= int'(PCT_MIN) || pct > int'(PCT_MAX)) begin
					r.read_failed = 1'b1;
					if (fails != FAIL_SAT)
						fails++;
					if (fails >= limit) begin
						if (chg_on) begin
							r.stop_charger = 1'b1;
							chg_on = 1'b0;
						end
						fails = '0;
					end
				end else begin
					fails = '0;
					if (pct < int'(low_pct))
						latch = 1'b1;
					if (latch) begin
						if (!chg_on) begin
							r.start_charger = 1'b1;
							chg_on = 1'b1;
						end
					end else if (chg_on) begin
						r.stop_charger = 1'b1;
						chg_on = 1'b0;
					end
					next_due = due_after(w.now_time);
				end
			end
			r.recharge_active = latch;
			due_q.push_back(r);
		endfunction

		function void check_word(logic [OUT_DATA_W-1:0] d);
			result_t want;
			result_t got;
			got = result_t'(d[5:0]);
			if (due_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word %b at %0t", d, $realtime);
				return;
			end
			want = due_q.pop_front();
			if (got.start_charger !== want.start_charger ||
			    got.stop_charger !== want.stop_charger ||
			    got.recharge_active !== want.recharge_active ||
			    got.read_failed !== want.read_failed ||
			    got.poll_action !== want.poll_action ||
			    d[7:6] !== 2'b00) begin
				errors++;
				if (errors <= 10)
					$display("mismatch at %0t: exp start %b stop %b rchg %b fail %b act %0d, got %b",
					         $realtime, want.start_charger, want.stop_charger,
					         want.recharge_active, want.read_failed, want.poll_action, d);
			end
		endfunction

		function int pending();
			return due_q.size();
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
	logic                    s_axis_tuser = 1'b0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]   m_axis_tdata;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;

	charge_policy_sb sb;
	item_t           seen_word;
	bit              tx_calm = 1'b0;
	bit              rx_calm = 1'b0;
	int              cycle_cnt = 0;

	wireless_pen_charge_policy i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				seen_word.cmd             = cmd_t'(s_axis_tuser);
				seen_word.now_time        = s_axis_tdata[47:0];
				seen_word.pen_removed     = s_axis_tdata[48];
				seen_word.host_off        = s_axis_tdata[49];
				seen_word.ext_power       = s_axis_tdata[50];
				seen_word.battery_percent = s_axis_tdata[58:51];
				sb.note_word(seen_word);
			end
			if (m_axis_tvalid && m_axis_tready)
				sb.check_word(m_axis_tdata);
		end
	end

	// mostly short idles, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 93)
			return $urandom_range(4, 8);
		return $urandom_range(9, 40);
	endfunction

	initial begin
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold == 0) begin
				if (rx_calm || $urandom_range(0, 99) < 65) begin
					m_axis_tready <= 1'b1;
					hold = $urandom_range(1, 12);
				end else begin
					m_axis_tready <= 1'b0;
					hold = idle_len();
				end
			end else begin
				hold--;
			end
		end
	end

	function automatic item_t mk(cmd_t c, logic [TIME_W-1:0] t, logic rem, logic off,
	                             logic ext, logic signed [BATT_W-1:0] b);
		item_t w;
		w.cmd = c;
		w.now_time = t;
		w.pen_removed = rem;
		w.host_off = off;
		w.ext_power = ext;
		w.battery_percent = b;
		return w;
	endfunction

	task automatic send(item_t w);
		int gap;
		gap = tx_calm ? 0 : (($urandom_range(0, 99) < 55) ? 0 : idle_len());
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata <= {5'b0, w.battery_percent, w.ext_power, w.host_off,
		                 w.pen_removed, w.now_time};
		s_axis_tuser <= w.cmd;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
		cfg_index <= idx;
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, v);
		@(negedge clk);
	endtask

	task automatic configure(logic [REV_W-1:0] rev, logic [IVL_W-1:0] ivl,
	                         logic [PCT_W-1:0] low, logic [FAIL_W-1:0] lim);
		settle();
		cfg_write(REG_BOARD_REV, {24'b0, rev});
		cfg_write(REG_CHECK_IVL, ivl);
		cfg_write(REG_LOW_PCT, {25'b0, low});
		cfg_write(REG_FAIL_LIMIT, {24'b0, lim});
		cfg_valid <= 1'b0;
	endtask

	task automatic directed();
		send(mk(CMD_POLL, 48'd0, 1'b0, 1'b0, 1'b0, 8'sd50));
		send(mk(CMD_POLL, 48'd5, 1'b0, 1'b0, 1'b1, 8'sd50));
		send(mk(CMD_POLL, TIME_MAX, 1'b0, 1'b0, 1'b0, 8'sd100));
		send(mk(CMD_POLL, 48'd1, 1'b1, 1'b0, 1'b1, 8'sd60));
		send(mk(CMD_POLL, 48'd2, 1'b0, 1'b1, 1'b0, 8'sd60));
		send(mk(CMD_POLL, 48'd3, 1'b0, 1'b1, 1'b1, 8'sd100));
		send(mk(CMD_END, 48'hFFFF_FFFF_0000, 1'b0, 1'b0, 1'b0, -8'sd128));
		send(mk(CMD_POLL, 48'd100, 1'b0, 1'b0, 1'b0, 8'sd0));
		send(mk(CMD_POLL, TIME_MAX, 1'b0, 1'b0, 1'b0, 8'sd0));
		send(mk(CMD_POLL, TIME_MAX, 1'b0, 1'b0, 1'b0, -8'sd128));
		send(mk(CMD_POLL, TIME_MAX, 1'b0, 1'b0, 1'b0, 8'sd127));
		send(mk(CMD_POLL, TIME_MAX, 1'b0, 1'b0, 1'b0, 8'sd101));
		send(mk(CMD_POLL, TIME_MAX, 1'b0, 1'b0, 1'b0, -8'sd1));
		send(mk(CMD_POLL, TIME_MAX, 1'b0, 1'b0, 1'b0, 8'sd1));
		send(mk(CMD_END, 48'd0, 1'b1, 1'b1, 1'b1, 8'sd100));
		// old board: polls ignored, end event still acts
		configure(8'd1, 32'hFFFF_FFFF, 7'd127, 8'd0);
		send(mk(CMD_POLL, 48'd0, 1'b1, 1'b1, 1'b0, 8'sd0));
		send(mk(CMD_END, 48'd0, 1'b0, 1'b0, 1'b0, 8'sd50));
		configure(8'd255, 32'd0, 7'd127, 8'd0);
		send(mk(CMD_POLL, 48'h1_0000_0000, 1'b0, 1'b0, 1'b0, 8'sd100));
		send(mk(CMD_POLL, 48'h1_0000_0000, 1'b0, 1'b0, 1'b0, 8'sd0));
		send(mk(CMD_POLL, 48'h1_0000_0000, 1'b0, 1'b0, 1'b0, 8'sd50));
		configure(8'd2, 32'd1000, 7'd0, 8'd1);
		send(mk(CMD_POLL, 48'h8000_0000_0000, 1'b0, 1'b0, 1'b0, 8'sd50));
		send(mk(CMD_POLL, 48'h8000_0000_0000, 1'b1, 1'b0, 1'b0, 8'sd50));
		send(mk(CMD_POLL, 48'h8000_0000_0001, 1'b0, 1'b0, 1'b0, 8'sd1));
		send(mk(CMD_POLL, 48'h8000_0000_1000, 1'b0, 1'b0, 1'b0, 8'sd0));
		configure(8'd3, 32'd1200000000, 7'd100, 8'd255);
		send(mk(CMD_POLL, 48'h9000_0000_0000, 1'b0, 1'b0, 1'b0, 8'sd99));
		send(mk(CMD_POLL, 48'hA000_0000_0000, 1'b0, 1'b0, 1'b0, 8'sd100));
	endtask

	initial begin
		logic [TIME_W-1:0]       now_us;
		logic [REV_W-1:0]        rev_v;
		logic [IVL_W-1:0]        ivl_v;
		logic [PCT_W-1:0]        low_v;
		logic [FAIL_W-1:0]       lim_v;
		logic signed [BATT_W-1:0] batt;
		cmd_t                    c;
		sb = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		directed();
		now_us = '0;
		for (int ph = 0; ph < PHASES; ph++) begin
			case ($urandom_range(0, 9))
				0: rev_v = 8'd0;
				1: rev_v = 8'd1;
				2: rev_v = 8'd255;
				default: rev_v = REV_W'($urandom_range(2, 10));
			endcase
			case ($urandom_range(0, 9))
				0: ivl_v = 32'd0;
				1: ivl_v = 32'hFFFF_FFFF;
				2: ivl_v = $urandom;
				default: ivl_v = $urandom_range(1, 5000);
			endcase
			case ($urandom_range(0, 9))
				0: low_v = 7'd0;
				1: low_v = 7'd100;
				2: low_v = 7'd127;
				default: low_v = PCT_W'($urandom_range(1, 100));
			endcase
			case ($urandom_range(0, 9))
				0: lim_v = 8'd0;
				1: lim_v = 8'd255;
				2: lim_v = 8'd1;
				default: lim_v = FAIL_W'($urandom_range(1, 6));
			endcase
			if (ph == 0) begin
				rev_v = 8'd255;
				ivl_v = 32'hFFFF_FFFF;
				low_v = 7'd127;
				lim_v = 8'd255;
			end else if (ph == 1) begin
				rev_v = 8'd2;
				ivl_v = 32'd0;
				low_v = 7'd0;
				lim_v = 8'd1;
			end
			configure(rev_v, ivl_v, low_v, lim_v);
			tx_calm = (ph % 4 == 3);
			rx_calm = (ph % 4 == 3);
			for (int k = 0; k < PHASE_WORDS; k++) begin
				case ($urandom_range(0, 9))
					0, 1, 2: now_us = now_us + $urandom_range(0, 3);
					8: now_us = TIME_W'({$urandom, $urandom});
					9: now_us = TIME_MAX - $urandom_range(0, 3);
					default: now_us = now_us + ivl_v + $urandom_range(0, 50);
				endcase
				if ($urandom_range(0, 99) < 65) begin
					batt = BATT_W'($urandom_range(1, 100));
				end else begin
					case ($urandom_range(0, 5))
						0: batt = 8'sd0;
						1: batt = -8'sd1;
						2: batt = 8'sd101;
						3: batt = 8'sd127;
						4: batt = -8'sd128;
						default: batt = BATT_W'($urandom);
					endcase
				end
				c = ($urandom_range(0, 99) < 6) ? CMD_END : CMD_POLL;
				send(mk(c, now_us, $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 12,
				        1'($urandom_range(0, 1)), batt));
			end
		end
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/wpcp_pkg.sv
hw/rtl/wpcp_regs.sv
hw/rtl/wpcp_step.sv
hw/rtl/wireless_pen_charge_policy.sv
hw/rtl/wpcp_check.sv
bench/wireless_pen_charge_policy_tb.sv
